// File: design/bhg_pkg.sv
// Package for the button hold gesture engine: field widths, configuration
// register indexes, LED bit positions and the request/result/config types.
// No dependencies.
package bhg_pkg;

   localparam int NOW_W         = 32;
   localparam int CFG_W         = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int TIME_BITS_DEF = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LED_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LED_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_DONE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_DONE  = 3'd5;

   // Reset values of the configuration registers
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd700;
   localparam logic [CFG_W-1:0] LED_FIRST_RST  = 16'd250;
   localparam logic [CFG_W-1:0] LED_STEP_RST   = 16'd250;
   localparam logic [CFG_W-1:0] ENTRY_DONE_RST = 16'd1500;
   localparam logic [CFG_W-1:0] EXIT_DONE_RST  = 16'd1250;

   // Bit positions in the LED level vector
   localparam int LED_SEL = 0;
   localparam int LED_A   = 1;
   localparam int LED_B   = 2;
   localparam int LED_C   = 3;

   typedef struct packed {
      logic [CFG_W-1:0] min_press_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] led_first_ms;
      logic [CFG_W-1:0] led_step_ms;
      logic [CFG_W-1:0] entry_done_ms;
      logic [CFG_W-1:0] exit_done_ms;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0] now_ms;
      logic             button_down;
      logic             pairing_active;
      logic             root_exit_armed;
      logic             menu_shown;
      logic             menu_escape_available;
   } req_type;

   typedef struct packed {
      logic event_valid;
      logic event_long;
      logic led_select;
      logic led_a;
      logic led_b;
      logic led_c;
      logic hold_active;
      logic enter_setup;
      logic leave_setup;
      logic cancel_preview;
   } rsp_type;

endpackage

// File: design/bhg_if.sv
// Channel interfaces of the button hold gesture engine: poll request,
// result and configuration write. Depends on bhg_pkg.
interface bhg_req_if import bhg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NOW_W-1:0] now_ms;
   logic             button_down;
   logic             pairing_active;
   logic             root_exit_armed;
   logic             menu_shown;
   logic             menu_escape_available;

   modport source (output valid, now_ms, button_down, pairing_active, root_exit_armed,
                   menu_shown, menu_escape_available, input ready);
   modport sink (input valid, now_ms, button_down, pairing_active, root_exit_armed,
                 menu_shown, menu_escape_available, output ready);
endinterface

interface bhg_rsp_if;
   logic valid;
   logic ready;
   logic event_valid;
   logic event_long;
   logic led_select;
   logic led_a;
   logic led_b;
   logic led_c;
   logic hold_active;
   logic enter_setup;
   logic leave_setup;
   logic cancel_preview;

   modport source (output valid, event_valid, event_long, led_select, led_a, led_b, led_c,
                   hold_active, enter_setup, leave_setup, cancel_preview, input ready);
   modport sink (input valid, event_valid, event_long, led_select, led_a, led_b, led_c,
                 hold_active, enter_setup, leave_setup, cancel_preview, output ready);
endinterface

interface bhg_csr_if import bhg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: design/bhg_csr.sv
// Configuration register file of the button hold gesture engine.
// Depends on bhg_pkg and bhg_csr_if.
module bhg_csr import bhg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bhg_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ms  <= DEBOUNCE_RST;
         cfg_ff.long_press_ms <= LONG_PRESS_RST;
         cfg_ff.led_first_ms  <= LED_FIRST_RST;
         cfg_ff.led_step_ms   <= LED_STEP_RST;
         cfg_ff.entry_done_ms <= ENTRY_DONE_RST;
         cfg_ff.exit_done_ms  <= EXIT_DONE_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_DEBOUNCE:   cfg_ff.min_press_ms  <= csr_bus.wdata;
            REG_LONG_PRESS: cfg_ff.long_press_ms <= csr_bus.wdata;
            REG_LED_FIRST:  cfg_ff.led_first_ms  <= csr_bus.wdata;
            REG_LED_STEP:   cfg_ff.led_step_ms   <= csr_bus.wdata;
            REG_ENTRY_DONE: cfg_ff.entry_done_ms <= csr_bus.wdata;
            REG_EXIT_DONE:  cfg_ff.exit_done_ms  <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

endmodule

// File: design/bhg_core.sv
// Gesture state machine: phase, press/hold timestamps, LED timelines and
// event decisions for one poll per cycle in which step is high. Depends on bhg_pkg.
module bhg_core import bhg_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int TL_W = CFG_W + 2;
   localparam int CW   = (TIME_BITS > TL_W) ? TIME_BITS : TL_W;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_PRE   = 3'd1;
   localparam logic [2:0] PH_ENTRY = 3'd2;
   localparam logic [2:0] PH_EXIT  = 3'd3;
   localparam logic [2:0] PH_CONN  = 3'd4;

   logic [2:0]           phase_ff, phase_in;
   logic                 prev_ff, prev_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic [TIME_BITS-1:0] hold_start_ff, hold_start_in;
   logic [TIME_BITS-1:0] tl_start_ff, tl_start_in;
   logic                 sup_ff, sup_in;
   logic                 entry_fin_ff, entry_fin_in;
   logic                 exit_fin_ff, exit_fin_in;
   logic [3:0]           leds_ff, leds_in;
   logic                 hold_ff, hold_in;

   logic [TIME_BITS-1:0] now_t, el_press, el_hold, el_tl;
   logic [TL_W-1:0]      t1, t2, t3, t4;
   logic [CW-1:0]        c1, c2, c3, c4;

   assign now_t    = item.now_ms[TIME_BITS-1:0];
   assign el_press = now_t - press_start_ff;
   assign el_hold  = now_t - hold_start_ff;
   assign el_tl    = now_t - tl_start_ff;

   // Timeline step boundaries; the widest one still fits in 18 bits.
   assign t1 = {2'b00, cfg.led_first_ms};
   assign t2 = t1 + {2'b00, cfg.led_step_ms};
   assign t3 = t2 + {2'b00, cfg.led_step_ms};
   assign t4 = t3 + {2'b00, cfg.led_step_ms};
   assign c1 = CW'(t1);
   assign c2 = CW'(t2);
   assign c3 = CW'(t3);
   assign c4 = CW'(t4);

   function automatic logic ge_cfg(input logic [TIME_BITS-1:0] e, input logic [CFG_W-1:0] t);
      return CW'(e) >= CW'(t);
   endfunction

   function automatic logic [3:0] entry_leds(input logic [TIME_BITS-1:0] e,
                                            input logic [CFG_W-1:0] done);
      logic [CW-1:0] ew;
      logic [3:0]    lv;
      ew = CW'(e);
      lv = '0;
      if (ew < c1) lv = '0;
      else if (ew < c2) lv[LED_B] = 1'b1;
      else if (ew < c3) begin
         lv[LED_B] = 1'b1;
         lv[LED_C] = 1'b1;
      end else if (ew < c4) begin
         lv[LED_B] = 1'b1;
         lv[LED_C] = 1'b1;
         lv[LED_A] = 1'b1;
      end else if (ew < CW'(done)) lv = 4'b1111;
      else lv = '0;
      return lv;
   endfunction

   function automatic logic [3:0] exit_leds(input logic [TIME_BITS-1:0] e);
      logic [CW-1:0] ew;
      logic [3:0]    lv;
      ew = CW'(e);
      lv = '0;
      if (ew < c1) lv = 4'b1111;
      else if (ew < c2) begin
         lv[LED_B] = 1'b1;
         lv[LED_C] = 1'b1;
         lv[LED_A] = 1'b1;
      end else if (ew < c3) begin
         lv[LED_B] = 1'b1;
         lv[LED_C] = 1'b1;
      end else if (ew < c4) lv[LED_B] = 1'b1;
      else lv = '0;
      return lv;
   endfunction

   always_comb begin
      logic down, pairing, armed, menu, esc, rel, hold_edge, mirror;
      logic ev, lng, enter, leave, cancel;
      down      = item.button_down;
      pairing   = item.pairing_active;
      armed     = pairing && item.root_exit_armed;
      menu      = item.menu_shown;
      esc       = item.menu_escape_available;
      rel       = !down && prev_ff;
      hold_edge = down && prev_ff;
      mirror    = 1'b1;
      ev        = 1'b0;
      lng       = 1'b0;
      enter     = 1'b0;
      leave     = 1'b0;
      cancel    = 1'b0;

      phase_in       = phase_ff;
      press_start_in = press_start_ff;
      hold_start_in  = hold_start_ff;
      tl_start_in    = tl_start_ff;
      sup_in         = sup_ff;
      entry_fin_in   = entry_fin_ff;
      exit_fin_in    = exit_fin_ff;
      leds_in        = leds_ff;
      hold_in        = hold_ff;

      case (phase_ff)
         PH_EXIT: begin
            hold_in = 1'b1;
            if (hold_edge) begin
               leds_in = exit_leds(el_hold);
               if (ge_cfg(el_hold, cfg.exit_done_ms) && !exit_fin_ff) begin
                  exit_fin_in = 1'b1;
                  leave       = 1'b1;
                  phase_in    = PH_IDLE;
                  hold_in     = 1'b0;
                  sup_in      = 1'b1;
               end
            end else if (rel) begin
               if (!exit_fin_ff) leds_in = '0;
               phase_in = PH_IDLE;
               hold_in  = 1'b0;
               mirror   = 1'b0;
            end
         end
         PH_PRE: begin
            if (rel) begin
               phase_in = PH_IDLE;
               cancel   = 1'b1;
               ev       = !sup_ff && ge_cfg(el_press, cfg.min_press_ms);
               lng      = ge_cfg(el_press, cfg.long_press_ms);
               sup_in   = 1'b0;
               mirror   = 1'b0;
            end else if (hold_edge && ge_cfg(el_press, cfg.long_press_ms)) begin
               cancel = 1'b1;
               if (menu && !pairing && esc) begin
                  ev       = 1'b1;
                  lng      = 1'b1;
                  phase_in = PH_IDLE;
                  sup_in   = 1'b1;
               end else begin
                  phase_in    = PH_ENTRY;
                  tl_start_in = now_t;
                  hold_in     = 1'b1;
                  leds_in     = entry_leds('0, cfg.entry_done_ms);
               end
            end
         end
         PH_ENTRY: begin
            hold_in          = 1'b1;
            leds_in[LED_SEL] = 1'b0;
            if (hold_edge) begin
               leds_in = entry_leds(el_tl, cfg.entry_done_ms);
               if (ge_cfg(el_tl, cfg.entry_done_ms) && !entry_fin_ff) begin
                  entry_fin_in = 1'b1;
                  enter        = 1'b1;
                  phase_in     = PH_IDLE;
                  hold_in      = 1'b0;
                  sup_in       = 1'b1;
               end
            end else if (rel) begin
               phase_in = PH_IDLE;
               if (!entry_fin_ff) begin
                  leds_in = '0;
                  hold_in = 1'b0;
                  ev      = !sup_ff && ge_cfg(el_press, cfg.min_press_ms);
                  lng     = ge_cfg(el_press, cfg.long_press_ms);
               end
               sup_in = 1'b0;
               mirror = 1'b0;
            end
         end
         PH_CONN: begin
            if (rel) begin
               phase_in = PH_IDLE;
               ev       = !sup_ff && ge_cfg(el_press, cfg.min_press_ms);
               lng      = ge_cfg(el_press, cfg.long_press_ms);
               sup_in   = 1'b0;
               mirror   = 1'b0;
            end else if (hold_edge && ge_cfg(el_press, cfg.long_press_ms)) begin
               if (armed) begin
                  phase_in      = PH_EXIT;
                  hold_start_in = now_t;
                  exit_fin_in   = 1'b0;
                  hold_in       = 1'b1;
                  leds_in       = exit_leds('0);
               end else begin
                  ev       = 1'b1;
                  lng      = 1'b1;
                  phase_in = PH_IDLE;
                  sup_in   = 1'b1;
               end
            end
         end
         default: begin
            if (down && !prev_ff) begin
               hold_start_in  = now_t;
               press_start_in = now_t;
               entry_fin_in   = 1'b0;
               exit_fin_in    = 1'b0;
               phase_in       = pairing ? PH_CONN : PH_PRE;
            end else if (rel) begin
               ev     = !sup_ff && ge_cfg(el_hold, cfg.min_press_ms);
               lng    = ge_cfg(el_hold, cfg.long_press_ms);
               sup_in = 1'b0;
            end
         end
      endcase

      // Select LED follows the button in idle (unless pairing/suppressed), pre and conn, except on release.
      if (mirror) begin
         if (phase_in == PH_IDLE) leds_in[LED_SEL] = !(pairing || sup_in) && down;
         else if (phase_in == PH_PRE || phase_in == PH_CONN) leds_in[LED_SEL] = down;
      end
      prev_in = down;

      result.event_valid    = ev;
      result.event_long     = ev && lng;
      result.led_select     = leds_in[LED_SEL];
      result.led_a          = leds_in[LED_A];
      result.led_b          = leds_in[LED_B];
      result.led_c          = leds_in[LED_C];
      result.hold_active    = hold_in;
      result.enter_setup    = enter;
      result.leave_setup    = leave;
      result.cancel_preview = cancel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         prev_ff        <= 1'b0;
         press_start_ff <= '0;
         hold_start_ff  <= '0;
         tl_start_ff    <= '0;
         sup_ff         <= 1'b0;
         entry_fin_ff   <= 1'b0;
         exit_fin_ff    <= 1'b0;
         leds_ff        <= '0;
         hold_ff        <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         prev_ff        <= prev_in;
         press_start_ff <= press_start_in;
         hold_start_ff  <= hold_start_in;
         tl_start_ff    <= tl_start_in;
         sup_ff         <= sup_in;
         entry_fin_ff   <= entry_fin_in;
         exit_fin_ff    <= exit_fin_in;
         leds_ff        <= leds_in;
         hold_ff        <= hold_in;
      end
   end

endmodule

// File: design/button_hold_gesture_engine.sv
// Button hold gesture engine, top level: request register, gesture core, result register.
// A request is held in the request register; its result is registered in the result
// register when that register is empty or its result is being taken.
// Throughput: one request per cycle while the result channel is not stalled; the state
// update for a request is done as it moves from the request register to the result register.
// Reset (synchronous, active high) clears the gesture state, the channel valids
// and loads the configuration registers with their default values.
module button_hold_gesture_engine import bhg_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bhg_req_if.sink   req_bus,
   bhg_rsp_if.source rsp_bus,
   bhg_csr_if.sink   csr_bus
);

   cfg_type cfg;
   req_type in_item_ff;
   logic    in_valid_ff;
   rsp_type core_result;
   rsp_type out_ff;
   logic    out_valid_ff;
   logic    advance;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   bhg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bhg_core #(.TIME_BITS(TIME_BITS)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.now_ms                <= req_bus.now_ms;
         in_item_ff.button_down           <= req_bus.button_down;
         in_item_ff.pairing_active        <= req_bus.pairing_active;
         in_item_ff.root_exit_armed       <= req_bus.root_exit_armed;
         in_item_ff.menu_shown            <= req_bus.menu_shown;
         in_item_ff.menu_escape_available <= req_bus.menu_escape_available;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.event_valid    = out_ff.event_valid;
   assign rsp_bus.event_long     = out_ff.event_long;
   assign rsp_bus.led_select     = out_ff.led_select;
   assign rsp_bus.led_a          = out_ff.led_a;
   assign rsp_bus.led_b          = out_ff.led_b;
   assign rsp_bus.led_c          = out_ff.led_c;
   assign rsp_bus.hold_active    = out_ff.hold_active;
   assign rsp_bus.enter_setup    = out_ff.enter_setup;
   assign rsp_bus.leave_setup    = out_ff.leave_setup;
   assign rsp_bus.cancel_preview = out_ff.cancel_preview;

endmodule
